>>> hdl/chbd_pkg.sv
// Shared types and constants for the chunked body decoder.
// Holds the classified byte item, parse phase encoding and result kinds.
// No dependencies.
package chbd_pkg;

  localparam int SizeBitsDefault = 32;
  localparam int QueueDepth      = 4;
  localparam int QueuePtrBits    = $clog2(QueueDepth);
  localparam int QueueCntBits    = $clog2(QueueDepth + 1);

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  typedef enum logic [7:0] {
    PH_LEAD   = 8'b0000_0001,
    PH_DIGITS = 8'b0000_0010,
    PH_EXT    = 8'b0000_0100,
    PH_LINECR = 8'b0000_1000,
    PH_DATA   = 8'b0001_0000,
    PH_TRAILA = 8'b0010_0000,
    PH_TRAILB = 8'b0100_0000,
    PH_DONE   = 8'b1000_0000
  } phase_t;

  // one body byte after classification
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       is_cr;
    logic       is_lf;
    logic       is_blank;
    logic       is_hex;
    logic [3:0] hex_val;
  } item_t;

  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b inside {[8'h30:8'h39]}) r = {1'b1, 4'(b - 8'h30)};
    else if (b inside {[8'h61:8'h66]}) r = {1'b1, 4'(b - 8'h57)};
    else if (b inside {[8'h41:8'h46]}) r = {1'b1, 4'(b - 8'h37)};
    return r;
  endfunction

endpackage

>>> hdl/chbd_front.sv
// Front end: takes raw body bytes and classifies them into items.
// Holds one registered item for the queue. Depends on chbd_pkg.
module chbd_front
  import chbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_start,
  output logic       item_valid,
  input  logic       item_ready,
  output item_t      item
);

  logic       valid;
  item_t      held;
  logic [4:0] hx;

  assign hx       = hex_decode(in_byte);
  assign in_ready = !valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held.data     <= in_byte;
      held.start    <= in_start;
      held.is_cr    <= (in_byte == ChCr);
      held.is_lf    <= (in_byte == ChLf);
      held.is_blank <= (in_byte == ChSpace) || (in_byte == ChTab);
      held.is_hex   <= hx[4];
      held.hex_val  <= hx[3:0];
    end
  end

  assign item_valid = valid;
  assign item       = held;

endmodule

>>> hdl/chbd_fifo.sv
// Short queue of classified items between front and back end.
// Depends on chbd_pkg for the item type and depth.
module chbd_fifo
  import chbd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  item_t push_item,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_item
);

  item_t                   entries [QueueDepth];
  logic [QueuePtrBits-1:0] wr_ptr;
  logic [QueuePtrBits-1:0] rd_ptr;
  logic [QueueCntBits-1:0] fill;

  assign full       = (fill == QueueCntBits'(QueueDepth));
  assign head_valid = (fill != '0);
  assign head_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

endmodule

>>> hdl/chbd_back.sv
// Back end: chunk parse state machine and registered result stage.
// Consumes classified items from the queue. Depends on chbd_pkg.
module chbd_back
  import chbd_pkg::*;
#(
  parameter int SIZE_BITS = SizeBitsDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  item_t      head_item,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data,
  output logic [1:0] out_kind
);

  phase_t                phase, phase_next, ph;
  logic [SIZE_BITS-1:0]  count, count_next, cnt, cnt_dec;
  logic                  res_valid;
  logic [1:0]            res_kind;
  logic [7:0]            res_data;

  assign pop = head_valid && (!out_valid || out_ready);

  always_comb begin
    // start of body restarts the parser on this very byte
    ph         = head_item.start ? PH_LEAD : phase;
    cnt        = head_item.start ? '0 : count;
    cnt_dec    = cnt - 1'b1;
    phase_next = ph;
    count_next = cnt;
    res_valid  = 1'b0;
    res_kind   = KIND_DATA;
    res_data   = 8'd0;
    case (ph)
      PH_LEAD, PH_DIGITS: begin
        if (head_item.is_cr) begin
          phase_next = PH_LINECR;
        end else if (ph == PH_LEAD && head_item.is_blank) begin
          phase_next = PH_LEAD;
        end else if (!head_item.is_hex) begin
          phase_next = PH_EXT;
        end else if (|cnt[SIZE_BITS-1 -: 4]) begin
          phase_next = PH_DONE;
          count_next = '0;
          res_valid  = 1'b1;
          res_kind   = KIND_ERR;
        end else begin
          phase_next = PH_DIGITS;
          count_next = {cnt[SIZE_BITS-5:0], head_item.hex_val};
        end
      end
      PH_EXT: begin
        if (head_item.is_cr) phase_next = PH_LINECR;
      end
      PH_LINECR: begin
        if (head_item.is_lf) begin
          if (cnt == '0) begin
            phase_next = PH_DONE;
            res_valid  = 1'b1;
            res_kind   = KIND_END;
          end else begin
            phase_next = PH_DATA;
          end
        end else if (head_item.is_cr) begin
          phase_next = PH_LINECR;
        end else begin
          phase_next = PH_EXT;
        end
      end
      PH_DATA: begin
        count_next = cnt_dec;
        if (cnt_dec == '0) phase_next = PH_TRAILA;
        res_valid = 1'b1;
        res_kind  = KIND_DATA;
        res_data  = head_item.data;
      end
      PH_TRAILA: phase_next = PH_TRAILB;
      PH_TRAILB: begin
        phase_next = PH_LEAD;
        count_next = '0;
      end
      PH_DONE: phase_next = PH_DONE;
      default: phase_next = PH_LEAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_LEAD;
      count     <= '0;
      out_valid <= 1'b0;
    end else if (pop) begin
      phase     <= phase_next;
      count     <= count_next;
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= res_data;
      out_kind <= res_kind;
    end
  end

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_kind == KIND_DATA || out_kind == KIND_END || out_kind == KIND_ERR))
    else $error("illegal result kind");

  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind != KIND_DATA) |-> (out_data == 8'd0))
    else $error("end or error result carries data");

  a_data_emits: assert property (@(posedge clk) disable iff (rst)
    (pop && !head_item.start && phase == PH_DATA) |=> (out_valid && out_kind == KIND_DATA))
    else $error("data byte not emitted");

  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    (pop && !head_item.start && phase == PH_DONE) |=> (!out_valid && phase == PH_DONE))
    else $error("result after end of body");

endmodule

>>> hdl/http_chunked_body_decoder.sv
// Chunked transfer body decoder, one body byte per item on each side.
// The front end classifies bytes, a short queue decouples it from the parser
// back end, which holds the chunk size and the registered result. After reset
// the block accepts at once. It takes one byte per cycle while m_tready does
// not hold the output back; an item passes the classify register, the queue
// and the result register in turn. Bytes that give no result (size lines,
// trailer CRLF, bytes after the end) are absorbed.
// Results: kind 0 payload byte, kind 1 end of body, kind 2 size overflow.
module http_chunked_body_decoder
  import chbd_pkg::*;
#(
  parameter int SIZE_BITS = SizeBitsDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] byte_in
  input  logic       s_tuser,   // [0] start_of_body
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] data_out
  output logic [1:0] m_tuser    // [1:0] kind
);

  logic  f_valid;
  logic  q_full;
  item_t f_item;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  chbd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .in_start   (s_tuser),
    .item_valid (f_valid),
    .item_ready (!q_full),
    .item       (f_item)
  );

  chbd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (f_valid && !q_full),
    .full       (q_full),
    .push_item  (f_item),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_item)
  );

  chbd_back #(
    .SIZE_BITS (SIZE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head_item  (q_item),
    .pop        (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata),
    .out_kind   (m_tuser)
  );

endmodule
